>>> rtl/contiguous_page_allocator_unit_assert.svh
// Assertion macros used by the contiguous page allocator top level.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// Condition a at a clock edge requires condition c at the same edge.
`define CPA_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("allocator check failed");

// Condition a at a clock edge requires condition c at the next edge.
`define CPA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("allocator check failed");

`endif

>>> rtl/cpa_pkg.sv
// Types and constants of the contiguous page allocator.
`default_nettype none

package cpa_pkg;

  // Widths of the request and response fields.
  localparam int unsigned KIND_W  = 1;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned TOTAL_W = 9;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } cpa_kind_t;

  // Controls that the sequencer drives to every cell at once.
  typedef struct packed {
    cpa_kind_t kind;
    logic      clr;
  } cpa_bcast_t;

endpackage

`default_nettype wire

>>> rtl/cpa_req_if.sv
// Request channel of the page allocator: valid, ready and the request beat.
`default_nettype none

interface cpa_req_if
  import cpa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COUNT_W-1:0] page_count;
  logic [PAGE_W-1:0]  base_page;

  modport source (output valid, kind, page_count, base_page, input ready);
  modport sink   (input valid, kind, page_count, base_page, output ready);
endinterface

`default_nettype wire

>>> rtl/cpa_rsp_if.sv
// Response channel of the page allocator: valid, ready and the result beat.
`default_nettype none

interface cpa_rsp_if
  import cpa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [PAGE_W-1:0]  first_page;
  logic [TOTAL_W-1:0] pages_left;

  modport source (output valid, ok, first_page, pages_left, input ready);
  modport sink   (input valid, ok, first_page, pages_left, output ready);
endinterface

`default_nettype wire

>>> rtl/contiguous_page_allocator_unit.sv
// Top level of the first-fit contiguous page allocator.
//
// Requests arrive on the req channel: kind 0 allocates page_count
// consecutive free pages, kind 1 frees page_count pages from base_page.
// Each request gives one beat on the rsp channel with ok, first_page and
// the free page count after the request.
// A token walks a row of NUM_PAGES cells, one cell per cycle, finding the
// lowest fitting run or freeing the range and counting newly freed pages.
// The response beat is presented once the token leaves the last cell, after
// an extra clear state for a successful allocation that clears the run,
// and straight from acceptance for an allocation of zero or more than
// NUM_PAGES pages. One request is in flight at a time, so a new request
// is not accepted until the response of the last one has been loaded.
// After reset no page is free; software frees the usable region first.
// The response is held in an output register: a new request is accepted
// while it waits, and a finished request waits until the receiver takes
// the held beat.
`default_nettype none

`include "contiguous_page_allocator_unit_assert.svh"

module contiguous_page_allocator_unit
  import cpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  cpa_req_if.sink   req,
  cpa_rsp_if.source rsp
);

  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned RW = (CW > 10) ? CW : 10;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WAVE  = 4'b0010,
    S_CLEAR = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state;
  cpa_kind_t          kind_q;
  logic [RW-1:0]      need;
  logic [RW-1:0]      lo;
  logic [RW-1:0]      hi;
  logic               launch;
  logic [CW-1:0]      free_total;
  logic               res_ok;
  logic [PW-1:0]      res_first;
  logic               rsp_valid;
  logic               rsp_ok;
  logic [PAGE_W-1:0]  rsp_first;
  logic [TOTAL_W-1:0] rsp_total;

  logic               accept;
  logic               reject;
  logic               out_free;
  logic               wave_done;
  logic [RW-1:0]      start_rw;
  cpa_bcast_t         bcast;

  // Token lines between cells; entry 0 is the launch point.
  logic               tv    [NUM_PAGES+1];
  logic [CW-1:0]      trun  [NUM_PAGES+1];
  logic               tfnd  [NUM_PAGES+1];
  logic [PW-1:0]      tidx  [NUM_PAGES+1];
  logic [CW-1:0]      tadd  [NUM_PAGES+1];

  logic               tail_valid;
  logic               tail_found;
  logic [PW-1:0]      tail_idx;
  logic [CW-1:0]      tail_add;

  // Handshake and decode of the request beat.
  always_comb begin
    req.ready  = (state == S_IDLE);
    accept     = req.valid && req.ready;
    reject     = (cpa_kind_t'(req.kind) == KIND_ALLOC) &&
                 ((req.page_count == '0) ||
                  (RW'(req.page_count) > RW'(NUM_PAGES)));
    out_free   = !rsp_valid || rsp.ready;
    wave_done  = (state == S_WAVE) && tail_valid;
    start_rw   = RW'(tail_idx) + RW'(1) - need;
    bcast.kind = kind_q;
    bcast.clr  = (state == S_CLEAR);
  end

  // Launch token: fresh run, nothing found, nothing freed.
  always_comb begin
    tv[0]   = launch;
    trun[0] = '0;
    tfnd[0] = 1'b0;
    tidx[0] = '0;
    tadd[0] = '0;
  end

  // Row of page cells.
  for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
    cpa_cell #(
      .IDX (g),
      .CW  (CW),
      .PW  (PW),
      .RW  (RW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bcast     (bcast),
      .need      (need),
      .lo        (lo),
      .hi        (hi),
      .in_valid  (tv[g]),
      .in_run    (trun[g]),
      .in_found  (tfnd[g]),
      .in_idx    (tidx[g]),
      .in_add    (tadd[g]),
      .out_valid (tv[g+1]),
      .out_run   (trun[g+1]),
      .out_found (tfnd[g+1]),
      .out_idx   (tidx[g+1]),
      .out_add   (tadd[g+1])
    );
  end

  // Token leaving the last cell.
  always_comb begin
    tail_valid = tv[NUM_PAGES];
    tail_found = tfnd[NUM_PAGES];
    tail_idx   = tidx[NUM_PAGES];
    tail_add   = tadd[NUM_PAGES];
  end

  // Sequencer, free count and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= 1'b0;
      free_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      launch <= accept && !reject;
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (reject) begin
              state <= S_DONE;
            end else begin
              state <= S_WAVE;
            end
          end
        end
        S_WAVE: begin
          if (tail_valid) begin
            if (kind_q == KIND_FREE) begin
              free_total <= free_total + tail_add;
              state      <= S_DONE;
            end else if (tail_found) begin
              free_total <= free_total - CW'(need);
              state      <= S_CLEAR;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CLEAR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields, result and response beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= cpa_kind_t'(req.kind);
      need      <= RW'(req.page_count);
      lo        <= RW'(req.base_page);
      hi        <= RW'(req.base_page) + RW'(req.page_count);
      res_ok    <= 1'b0;
      res_first <= '0;
    end
    if (wave_done) begin
      if (kind_q == KIND_FREE) begin
        res_ok <= 1'b1;
      end else if (tail_found) begin
        res_ok    <= 1'b1;
        res_first <= start_rw[PW-1:0];
        lo        <= start_rw;
        hi        <= start_rw + need;
      end
    end
    if ((state == S_DONE) && out_free) begin
      rsp_ok    <= res_ok;
      rsp_first <= PAGE_W'(res_first);
      rsp_total <= TOTAL_W'(free_total);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.ok         = rsp_ok;
  assign rsp.first_page = rsp_first;
  assign rsp.pages_left = rsp_total;

  // Checks on the sequencer and the free count.
  `CPA_ASSERT_IMPLY(a_total_bound, clk, rst, 1'b1, free_total <= CW'(NUM_PAGES))
  `CPA_ASSERT_IMPLY(a_tail_in_wave, clk, rst, tail_valid, state == S_WAVE)
  `CPA_ASSERT_IMPLY(a_clear_after_hit, clk, rst, state == S_CLEAR, kind_q == KIND_ALLOC && res_ok)
  `CPA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != S_IDLE)
  `CPA_ASSERT_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, rsp_valid)

endmodule

`default_nettype wire

>>> rtl/cpa_cell.sv
// One page cell: holds the page's free bit and forwards the scan token.
`default_nettype none

module cpa_cell
  import cpa_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9,
  parameter int unsigned PW  = 8,
  parameter int unsigned RW  = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cpa_bcast_t    bcast,
  input  wire logic [RW-1:0] need,
  input  wire logic [RW-1:0] lo,
  input  wire logic [RW-1:0] hi,
  input  wire logic          in_valid,
  input  wire logic [CW-1:0] in_run,
  input  wire logic          in_found,
  input  wire logic [PW-1:0] in_idx,
  input  wire logic [CW-1:0] in_add,
  output logic               out_valid,
  output logic [CW-1:0]      out_run,
  output logic               out_found,
  output logic [PW-1:0]      out_idx,
  output logic [CW-1:0]      out_add
);

  logic          page_free;
  logic          in_range;
  logic [CW-1:0] run_next;
  logic          hit;
  logic          newly_freed;

  // Range check against this cell's fixed page number, run length, hit and newly freed flag.
  always_comb begin
    in_range    = (RW'(IDX) >= lo) && (RW'(IDX) < hi);
    run_next    = page_free ? in_run + CW'(1) : '0;
    hit         = !in_found && (RW'(run_next) == need);
    newly_freed = (bcast.kind == KIND_FREE) && in_range && !page_free;
  end

  // Free bit: set as a free token passes, cleared by the range clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_free <= 1'b0;
    end else if (bcast.clr && in_range) begin
      page_free <= 1'b0;
    end else if (in_valid && (bcast.kind == KIND_FREE) && in_range) begin
      page_free <= 1'b1;
    end
  end

  // Token valid moves one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Token payload: run length, first hit and count of newly freed pages.
  always_ff @(posedge clk) begin
    out_run   <= run_next;
    out_found <= in_found || hit;
    out_idx   <= hit ? PW'(IDX) : in_idx;
    out_add   <= in_add + CW'(newly_freed);
  end

endmodule

`default_nettype wire
